// ===== rtl/bsd_pkg.sv =====
// Package: widths, constants and types shared by the box distance block.
`timescale 1ns / 1ps
`default_nettype none
package bsd_pkg;

    localparam int CW     = 32;          // coordinate width
    localparam int FRAC   = 16;          // fraction bits
    localparam int HW     = CW - 1;      // half extent / excess width
    localparam int DW     = CW + 1;      // difference width
    localparam int SQW    = 2 * HW;      // square width
    localparam int SUMW   = 2 * CW;      // sum of squares width
    localparam int REMW   = CW + 2;      // root remainder width
    localparam int STEPS  = CW;          // root bits, one per stage
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int CIW    = 3;           // config index width

    localparam logic [CW-1:0] DIST_MAX    = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] DIST_INSIDE = {{(CW-FRAC){1'b1}}, {FRAC{1'b0}}};
    localparam logic [HW-1:0] HALF_ONE    = {{(HW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

    localparam logic [CIW-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CIW-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CIW-1:0] REG_CENTER_Z    = 3'd2;
    localparam logic [CIW-1:0] REG_HALF_WIDTH  = 3'd3;
    localparam logic [CIW-1:0] REG_HALF_HEIGHT = 3'd4;
    localparam logic [CIW-1:0] REG_HALF_LENGTH = 3'd5;

    typedef enum logic [1:0] {
        K_CALC   = 2'd0,
        K_INSIDE = 2'd1,
        K_SAT    = 2'd2
    } t_kind;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [CW-1:0] distance;
        logic                 saturated;
    } t_result;

    typedef struct packed {
        logic [CW-1:0] center_x;
        logic [CW-1:0] center_y;
        logic [CW-1:0] center_z;
        logic [HW-1:0] half_width;
        logic [HW-1:0] half_height;
        logic [HW-1:0] half_length;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        t_kind         kind;
        logic [HW-1:0] ex;
        logic [HW-1:0] ey;
        logic [HW-1:0] ez;
    } t_cls;

endpackage
`default_nettype wire

// ===== rtl/bsd_front.sv =====
// Front end: per-axis offsets, inside test and excess classification.
`timescale 1ns / 1ps
`default_nettype none
module bsd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bsd_pkg::t_cfg  i_cfg,
    input  wire logic           push,
    input  wire bsd_pkg::t_point i_point,
    output logic                full,
    input  wire logic           i_q_ready,
    output logic                o_q_push,
    output bsd_pkg::t_cls       o_q_data
);

    logic                  r_va, r_vb, r_vc;
    logic [bsd_pkg::DW-1:0] r_d [3];
    logic [bsd_pkg::DW-1:0] r_a [3];
    bsd_pkg::t_cls          r_cls;
    logic                  en;

    logic [bsd_pkg::CW-1:0] p [3];
    logic [bsd_pkg::CW-1:0] c [3];
    logic [bsd_pkg::HW-1:0] h [3];
    logic [bsd_pkg::DW-1:0] n_d [3];
    logic [bsd_pkg::DW-1:0] n_a [3];
    logic [bsd_pkg::DW-1:0] e [3];
    logic [2:0]             in_ax, sat_ax;
    bsd_pkg::t_cls          n_cls;

    assign en       = !r_vc || i_q_ready;
    assign full     = !en;
    assign o_q_push = r_vc && i_q_ready;
    assign o_q_data = r_cls;

    always_comb begin
        p[0] = i_point.point_x;
        p[1] = i_point.point_y;
        p[2] = i_point.point_z;
        c[0] = i_cfg.center_x;
        c[1] = i_cfg.center_y;
        c[2] = i_cfg.center_z;
        h[0] = i_cfg.half_width;
        h[1] = i_cfg.half_height;
        h[2] = i_cfg.half_length;
        for (int i = 0; i < 3; i++) begin
            n_d[i] = {p[i][bsd_pkg::CW-1], p[i]} - {c[i][bsd_pkg::CW-1], c[i]};
            n_a[i] = r_d[i][bsd_pkg::DW-1] ? (~r_d[i] + bsd_pkg::DW'(1)) : r_d[i];
            in_ax[i] = r_a[i] < {2'b00, h[i]};
            e[i] = (r_a[i] > {2'b00, h[i]}) ? (r_a[i] - {2'b00, h[i]}) : '0;
            sat_ax[i] = e[i][bsd_pkg::DW-1:bsd_pkg::HW] != 2'b00;
        end
        if (&in_ax) begin
            n_cls.kind = bsd_pkg::K_INSIDE;
        end else if (|sat_ax) begin
            n_cls.kind = bsd_pkg::K_SAT;
        end else begin
            n_cls.kind = bsd_pkg::K_CALC;
        end
        n_cls.ex = e[0][bsd_pkg::HW-1:0];
        n_cls.ey = e[1][bsd_pkg::HW-1:0];
        n_cls.ez = e[2][bsd_pkg::HW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (en) begin
            r_va <= push;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d   <= n_d;
            r_a   <= n_a;
            r_cls <= n_cls;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bsd_queue.sv =====
// Short show-ahead queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module bsd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bsd_pkg::t_cls i_data,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_pop,
    output bsd_pkg::t_cls      o_data
);

    bsd_pkg::t_cls           r_mem [bsd_pkg::QDEPTH];
    logic [bsd_pkg::QPW-1:0] r_wp, r_rp;
    logic [bsd_pkg::QPW:0]   r_cnt;

    assign o_ready = r_cnt != bsd_pkg::QPW'(0) + (bsd_pkg::QPW+1)'(bsd_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

// ===== rtl/bsd_back.sv =====
// Back end: squares, sum, pipelined bit-per-stage square root, result buffer.
`timescale 1ns / 1ps
`default_nettype none
module bsd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire bsd_pkg::t_cls i_q_data,
    output logic               o_q_pop,
    output logic               empty,
    input  wire logic          pop,
    output bsd_pkg::t_result   o_result
);

    localparam int S = bsd_pkg::STEPS;

    logic                     en;
    // square stage
    logic                     r_v0;
    bsd_pkg::t_kind           r_k0;
    logic [bsd_pkg::SQW-1:0]  r_sqx, r_sqy, r_sqz;
    // sum stage
    logic                     r_v1;
    bsd_pkg::t_kind           r_k1;
    logic [bsd_pkg::SUMW-1:0] r_sum;
    // root stages
    logic                     r_v   [S];
    bsd_pkg::t_kind           r_k   [S];
    logic [bsd_pkg::SUMW-1:0] r_rad [S];
    logic [bsd_pkg::REMW-1:0] r_rem [S];
    logic [bsd_pkg::CW-1:0]   r_root[S];
    logic [bsd_pkg::SUMW-1:0] n_rad [S];
    logic [bsd_pkg::REMW-1:0] n_rem [S];
    logic [bsd_pkg::CW-1:0]   n_root[S];
    // result buffer
    bsd_pkg::t_result         r_obuf[2];
    logic                     r_owp, r_orp;
    logic [1:0]               r_ocnt;
    bsd_pkg::t_result         n_res;
    logic                     o_wr, o_rd;

    logic [bsd_pkg::SUMW-1:0] s_rad;
    logic [bsd_pkg::REMW-1:0] s_rem;
    logic [bsd_pkg::CW-1:0]   s_root;
    logic [bsd_pkg::REMW+1:0] w, trial;

    assign o_rd    = pop && !empty;
    assign en      = !(r_v[S-1] && r_ocnt == 2'd2 && !o_rd);
    assign o_q_pop = en && i_q_valid;
    assign o_wr    = en && r_v[S-1];
    assign empty   = r_ocnt == 2'd0;
    assign o_result = r_obuf[r_orp];

    always_comb begin
        for (int k = 0; k < S; k++) begin
            if (k == 0) begin
                s_rad  = r_sum;
                s_rem  = '0;
                s_root = '0;
            end else begin
                s_rad  = r_rad[k-1];
                s_rem  = r_rem[k-1];
                s_root = r_root[k-1];
            end
            w     = {s_rem, s_rad[bsd_pkg::SUMW-1 -: 2]};
            trial = {2'b00, s_root, 2'b01};
            if (w >= trial) begin
                n_rem[k]  = bsd_pkg::REMW'(w - trial);
                n_root[k] = {s_root[bsd_pkg::CW-2:0], 1'b1};
            end else begin
                n_rem[k]  = w[bsd_pkg::REMW-1:0];
                n_root[k] = {s_root[bsd_pkg::CW-2:0], 1'b0};
            end
            n_rad[k] = {s_rad[bsd_pkg::SUMW-3:0], 2'b00};
        end
    end

    always_comb begin
        case (r_k[S-1])
            bsd_pkg::K_INSIDE: begin
                n_res.distance  = bsd_pkg::DIST_INSIDE;
                n_res.saturated = 1'b0;
            end
            bsd_pkg::K_SAT: begin
                n_res.distance  = bsd_pkg::DIST_MAX;
                n_res.saturated = 1'b1;
            end
            bsd_pkg::K_CALC: begin
                if (r_root[S-1][bsd_pkg::CW-1]) begin
                    n_res.distance  = bsd_pkg::DIST_MAX;
                    n_res.saturated = 1'b1;
                end else begin
                    n_res.distance  = r_root[S-1];
                    n_res.saturated = 1'b0;
                end
            end
            default: begin
                n_res.distance  = bsd_pkg::DIST_MAX;
                n_res.saturated = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            for (int k = 0; k < S; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v0 <= i_q_valid;
            r_v1 <= r_v0;
            r_v[0] <= r_v1;
            for (int k = 1; k < S; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k0  <= i_q_data.kind;
            r_sqx <= i_q_data.ex * i_q_data.ex;
            r_sqy <= i_q_data.ey * i_q_data.ey;
            r_sqz <= i_q_data.ez * i_q_data.ez;
            r_k1  <= r_k0;
            r_sum <= {2'b00, r_sqx} + {2'b00, r_sqy} + {2'b00, r_sqz};
            r_k[0] <= r_k1;
            for (int k = 1; k < S; k++) r_k[k] <= r_k[k-1];
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (o_wr) r_owp <= ~r_owp;
            if (o_rd) r_orp <= ~r_orp;
            case ({o_wr, o_rd})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_wr) r_obuf[r_owp] <= n_res;
    end

endmodule
`default_nettype wire

// ===== rtl/box_signed_distance.sv =====
// Top level: configuration registers, front end, queue and back end.
//
// Signed distance from a point to an axis-aligned box, Q16.16 fixed point.
// Input: drive i_point and raise push; a transfer happens at a rising edge
// with push high and full low. Results: while empty is low, o_result holds
// the oldest result; it transfers at a rising edge with pop high.
// Configuration: i_cfg_we with i_cfg_idx (0..2 center x/y/z, 3..5 half
// extents x/y/z) and i_cfg_data; other indexes are ignored. Write only idle.
// Throughput: one point per cycle while full is low. A point passes the 3
// front stages, the queue, the square and sum stages and the 32-stage square
// root (one root bit per stage) on its way from the input transfer to o_result.
// Reset clears all queues and pipelines; centers go to 0, half extents to 1.0.
// When pop stays low, results collect in a two-entry buffer, the back end
// then halts, the 4-entry queue fills, and full rises to hold off pushes.
`timescale 1ns / 1ps
`default_nettype none
module box_signed_distance (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [bsd_pkg::CIW-1:0]  i_cfg_idx,
    input  wire logic [bsd_pkg::CW-1:0]   i_cfg_data,
    input  wire logic                     push,
    output logic                          full,
    input  wire bsd_pkg::t_point          i_point,
    output logic                          empty,
    input  wire logic                     pop,
    output bsd_pkg::t_result              o_result
);

    bsd_pkg::t_cfg r_cfg;
    logic          q_ready, q_push, q_valid, q_pop;
    bsd_pkg::t_cls q_in, q_out;
    logic          accept;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x    <= '0;
            r_cfg.center_y    <= '0;
            r_cfg.center_z    <= '0;
            r_cfg.half_width  <= bsd_pkg::HALF_ONE;
            r_cfg.half_height <= bsd_pkg::HALF_ONE;
            r_cfg.half_length <= bsd_pkg::HALF_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bsd_pkg::REG_CENTER_X:    r_cfg.center_x    <= i_cfg_data;
                bsd_pkg::REG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data;
                bsd_pkg::REG_CENTER_Z:    r_cfg.center_z    <= i_cfg_data;
                bsd_pkg::REG_HALF_WIDTH:  r_cfg.half_width  <= i_cfg_data[bsd_pkg::HW-1:0];
                bsd_pkg::REG_HALF_HEIGHT: r_cfg.half_height <= i_cfg_data[bsd_pkg::HW-1:0];
                bsd_pkg::REG_HALF_LENGTH: r_cfg.half_length <= i_cfg_data[bsd_pkg::HW-1:0];
                default: ;
            endcase
        end
    end

    bsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .push      (accept),
        .i_point   (i_point),
        .full      (full),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_data  (q_in)
    );

    bsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    bsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/bsd_checker.sv =====
// Port-level checker for the box distance block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bsd_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             empty,
    input wire logic             pop,
    input wire bsd_pkg::t_result o_result
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.saturated) |-> (o_result.distance == bsd_pkg::DIST_MAX))
        else $error("saturated result without maximum distance");

    a_negative_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.distance[bsd_pkg::CW-1]) |->
        (o_result.distance == bsd_pkg::DIST_INSIDE && !o_result.saturated))
        else $error("negative distance other than inside code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result lost or changed");

endmodule

bind box_signed_distance bsd_checker u_bsd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
`default_nettype wire
